// File: rtl/core/fbcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbcm_pkg;

  // command carried in the input tuser
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // verdict of one word
  typedef enum logic [2:0] {
    VERDICT_GOOD        = 3'd0,
    VERDICT_ALREADY_BAD = 3'd1,
    VERDICT_IN_FILE     = 3'd2,
    VERDICT_MARKED      = 3'd3,
    VERDICT_RANGE       = 3'd4
  } verdict_e;

  // fat layout constants
  localparam logic [15:0] SMALL_FAT_LIMIT = 16'd4086;
  localparam logic [11:0] MARK12          = 12'hFF7;
  localparam logic [15:0] MARK16          = 16'hFFF7;

  // stream widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 80;

endpackage

`default_nettype wire

// File: rtl/core/fbcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fbcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire                     clk_i,
  input  wire                     en_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] addr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read, read data holds when idle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fat_bad_cluster_marker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// load and clear give their result word in the cycle after acceptance; read and check first
// read the fat banks, then evaluate and register the result, writing back a new bad mark
// load and clear go back to back when the output is free; read and check block input meanwhile
// the fat store is split in an even and an odd byte bank so both entry bytes move at once
// reset: async active low, clears counters and handshake state, cluster_count becomes 4086;
// fat store contents are undefined until loaded

module fat_bad_cluster_marker_core #(
  parameter int unsigned FAT_BYTES = 16384
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration: cluster_count
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [13:0] byte_addr, [21:14] byte_value, [37:22] cluster, [38] read_failed
  input  wire  [fbcm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] cmd
  input  wire  [1:0]  s_axis_tuser,
  // output stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [2:0] verdict, [18:3] entry_value, [26:19] read_byte, [42:27] bad_total,
  // [58:43] bad_new, [74:59] bad_in_file, [79:75] zero
  output logic [fbcm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned BANK_DEPTH = FAT_BYTES / 2;
  localparam int unsigned BAW        = $clog2(BANK_DEPTH);

  typedef enum logic {ST_IDLE, ST_RESP} st_e;

  st_e              state_q, state_d;
  logic             m_valid_q, m_valid_d;
  logic [15:0]      cluster_count_q, cluster_count_d;
  logic [15:0]      total_q, total_d, new_q, new_d, file_q, file_d;
  logic [2:0]       verdict_q, verdict_d;
  logic [15:0]      entry_q, entry_d;
  logic [7:0]       rbyte_q, rbyte_d;

  // item held across the memory read
  fbcm_pkg::cmd_e   cmd_q, cmd_d;
  logic             small_q, small_d;
  logic             c_odd_q, c_odd_d;
  logic             off_odd_q, off_odd_d;
  logic             oor_q, oor_d;
  logic             failed_q, failed_d;
  logic [BAW-1:0]   a0_q, a0_d, a1_q, a1_d;

  // input fields
  fbcm_pkg::cmd_e   in_cmd;
  logic [13:0]      in_addr;
  logic [7:0]       in_byte;
  logic [15:0]      in_cluster;
  logic             in_failed;

  logic             in_acc, out_free, small_fat;
  logic [17:0]      off_small, off;
  logic             oor, addr_ok;
  logic [BAW-1:0]   addr_idx, ck_idx0, ck_idx1;

  // bank ports
  logic [1:0]       ram_en, ram_we;
  logic [BAW-1:0]   ram_addr [2];
  logic [7:0]       ram_wdata [2];
  logic [7:0]       ram_rdata [2];

  // evaluation
  logic [15:0]      word, entry, mark, word_new;
  fbcm_pkg::verdict_e chk_verdict;

  assign in_cmd     = fbcm_pkg::cmd_e'(s_axis_tuser);
  assign in_addr    = s_axis_tdata[13:0];
  assign in_byte    = s_axis_tdata[21:14];
  assign in_cluster = s_axis_tdata[37:22];
  assign in_failed  = s_axis_tdata[38];

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, file_q, new_q, total_q, rbyte_q, entry_q, verdict_q};

  // entry offset and range check
  assign small_fat = cluster_count_q <= fbcm_pkg::SMALL_FAT_LIMIT;
  assign off_small = ({2'b00, in_cluster} + {1'b0, in_cluster, 1'b0}) >> 1;
  assign off       = small_fat ? off_small : {1'b0, in_cluster, 1'b0};
  assign oor       = (in_cluster < 16'd2)
                  || ({1'b0, in_cluster} > ({1'b0, cluster_count_q} + 17'd1))
                  || ((32'(off) + 32'd1) >= 32'(FAT_BYTES));
  assign addr_ok   = 32'(in_addr) < 32'(FAT_BYTES);
  assign addr_idx  = BAW'(32'(in_addr) >> 1);
  // low byte sits in bank off[0], high byte in the other bank
  assign ck_idx0   = BAW'((32'(off) + 32'd1) >> 1);
  assign ck_idx1   = BAW'(32'(off) >> 1);

  // entry read from both banks
  assign word  = off_odd_q ? {ram_rdata[0], ram_rdata[1]} : {ram_rdata[1], ram_rdata[0]};
  assign entry = small_q ? (c_odd_q ? {4'd0, word[15:4]} : {4'd0, word[11:0]}) : word;
  assign mark  = small_q ? {4'd0, fbcm_pkg::MARK12} : fbcm_pkg::MARK16;

  always_comb begin
    priority if (oor_q) begin
      chk_verdict = fbcm_pkg::VERDICT_RANGE;
    end else if (entry == mark) begin
      chk_verdict = fbcm_pkg::VERDICT_ALREADY_BAD;
    end else if (failed_q && entry != 16'd0) begin
      chk_verdict = fbcm_pkg::VERDICT_IN_FILE;
    end else if (failed_q) begin
      chk_verdict = fbcm_pkg::VERDICT_MARKED;
    end else begin
      chk_verdict = fbcm_pkg::VERDICT_GOOD;
    end
  end

  // bad mark merged into the entry word
  always_comb begin
    if (!small_q) begin
      word_new = fbcm_pkg::MARK16;
    end else if (c_odd_q) begin
      word_new = {fbcm_pkg::MARK12, word[3:0]};
    end else begin
      word_new = {word[15:12], fbcm_pkg::MARK12};
    end
  end

  // bank port control
  always_comb begin
    ram_en       = 2'b00;
    ram_we       = 2'b00;
    ram_addr[0]  = a0_q;
    ram_addr[1]  = a1_q;
    ram_wdata[0] = off_odd_q ? word_new[15:8] : word_new[7:0];
    ram_wdata[1] = off_odd_q ? word_new[7:0] : word_new[15:8];
    if (state_q == ST_IDLE && in_acc) begin
      unique case (in_cmd)
        fbcm_pkg::CMD_LOAD: begin
          ram_en[in_addr[0]]    = addr_ok;
          ram_we[in_addr[0]]    = addr_ok;
          ram_addr[in_addr[0]]  = addr_idx;
          ram_wdata[in_addr[0]] = in_byte;
        end
        fbcm_pkg::CMD_READ: begin
          ram_en[in_addr[0]]   = addr_ok;
          ram_addr[in_addr[0]] = addr_idx;
        end
        fbcm_pkg::CMD_CHECK: begin
          ram_en      = {2{!oor}};
          ram_addr[0] = ck_idx0;
          ram_addr[1] = ck_idx1;
        end
        fbcm_pkg::CMD_CLEAR: begin
          ram_en = 2'b00;
        end
        default: begin
          ram_en = 2'b00;
        end
      endcase
    end else if (state_q == ST_RESP && out_free && cmd_q == fbcm_pkg::CMD_CHECK
                 && chk_verdict == fbcm_pkg::VERDICT_MARKED) begin
      ram_en = 2'b11;
      ram_we = 2'b11;
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    fbcm_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .en_i    (ram_en[b]),
      .we_i    (ram_we[b]),
      .addr_i  (ram_addr[b]),
      .wdata_i (ram_wdata[b]),
      .rdata_o (ram_rdata[b])
    );
  end

  // next state, counters and result word
  always_comb begin
    state_d         = state_q;
    m_valid_d       = m_valid_q && !m_axis_tready;
    cluster_count_d = cfg_valid_i ? cfg_data_i : cluster_count_q;
    total_d         = total_q;
    new_d           = new_q;
    file_d          = file_q;
    verdict_d       = verdict_q;
    entry_d         = entry_q;
    rbyte_d         = rbyte_q;
    cmd_d           = cmd_q;
    small_d         = small_q;
    c_odd_d         = c_odd_q;
    off_odd_d       = off_odd_q;
    oor_d           = oor_q;
    failed_d        = failed_q;
    a0_d            = a0_q;
    a1_d            = a1_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d     = in_cmd;
          small_d   = small_fat;
          c_odd_d   = in_cluster[0];
          failed_d  = in_failed;
          a0_d      = ck_idx0;
          a1_d      = ck_idx1;
          off_odd_d = (in_cmd == fbcm_pkg::CMD_CHECK) ? off[0] : in_addr[0];
          oor_d     = (in_cmd == fbcm_pkg::CMD_CHECK) ? oor : !addr_ok;
          if (in_cmd == fbcm_pkg::CMD_LOAD || in_cmd == fbcm_pkg::CMD_CLEAR) begin
            m_valid_d = 1'b1;
            verdict_d = fbcm_pkg::VERDICT_GOOD;
            entry_d   = 16'd0;
            rbyte_d   = 8'd0;
            if (in_cmd == fbcm_pkg::CMD_CLEAR) begin
              total_d = 16'd0;
              new_d   = 16'd0;
              file_d  = 16'd0;
            end
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
          if (cmd_q == fbcm_pkg::CMD_READ) begin
            verdict_d = fbcm_pkg::VERDICT_GOOD;
            entry_d   = 16'd0;
            rbyte_d   = oor_q ? 8'd0 : (off_odd_q ? ram_rdata[1] : ram_rdata[0]);
          end else begin
            verdict_d = chk_verdict;
            entry_d   = oor_q ? 16'd0 : entry;
            rbyte_d   = 8'd0;
            if (chk_verdict == fbcm_pkg::VERDICT_ALREADY_BAD
                || chk_verdict == fbcm_pkg::VERDICT_IN_FILE
                || chk_verdict == fbcm_pkg::VERDICT_MARKED) begin
              total_d = (total_q == 16'hFFFF) ? total_q : total_q + 16'd1;
            end
            if (chk_verdict == fbcm_pkg::VERDICT_IN_FILE) begin
              file_d = (file_q == 16'hFFFF) ? file_q : file_q + 16'd1;
            end
            if (chk_verdict == fbcm_pkg::VERDICT_MARKED) begin
              new_d = (new_q == 16'hFFFF) ? new_q : new_q + 16'd1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, counters and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      m_valid_q       <= 1'b0;
      cluster_count_q <= fbcm_pkg::SMALL_FAT_LIMIT;
      total_q         <= 16'd0;
      new_q           <= 16'd0;
      file_q          <= 16'd0;
      verdict_q       <= fbcm_pkg::VERDICT_GOOD;
      entry_q         <= 16'd0;
      rbyte_q         <= 8'd0;
    end else begin
      state_q         <= state_d;
      m_valid_q       <= m_valid_d;
      cluster_count_q <= cluster_count_d;
      total_q         <= total_d;
      new_q           <= new_d;
      file_q          <= file_d;
      verdict_q       <= verdict_d;
      entry_q         <= entry_d;
      rbyte_q         <= rbyte_d;
    end
  end

  // item held across the read, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    small_q   <= small_d;
    c_odd_q   <= c_odd_d;
    off_odd_q <= off_odd_d;
    oor_q     <= oor_d;
    failed_q  <= failed_d;
    a0_q      <= a0_d;
    a1_q      <= a1_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/fbcm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fbcm_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                s_axis_tvalid,
  input wire                                s_axis_tready,
  input wire [1:0]                          s_axis_tuser,
  input wire                                m_axis_tvalid,
  input wire                                m_axis_tready,
  input wire [fbcm_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  // a stalled result blocks new words
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // a stalled result word holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // clear shows all counters at zero on the next cycle
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == fbcm_pkg::CMD_CLEAR)
    |=> (m_axis_tvalid && m_axis_tdata[74:27] == 48'd0))
    else $error("clear result wrong");

  // load answers on the next cycle with a plain good verdict
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == fbcm_pkg::CMD_LOAD)
    |=> (m_axis_tvalid && m_axis_tdata[2:0] == fbcm_pkg::VERDICT_GOOD
         && m_axis_tdata[26:3] == 24'd0))
    else $error("load result wrong");

endmodule

bind fat_bad_cluster_marker_core fbcm_checker u_fbcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: verif/tb_fat_bad_cluster_marker_core.sv
`timescale 1ns / 1ps

module tb_fat_bad_cluster_marker_core;

  localparam int unsigned FAT_BYTES         = 16384;
  localparam int unsigned CYCLE_LIMIT       = 100_000;
  localparam int unsigned LONG_STALL_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES     = 4;

  // one result word, split into its fields
  typedef struct packed {
    fbcm_pkg::verdict_e verdict;
    logic [15:0] entry;
    logic [7:0]  rd_byte;
    logic [15:0] total;
    logic [15:0] fresh;
    logic [15:0] in_file;
  } fat_result_t;

  // what a prepared entry should hold
  typedef enum logic [1:0] {
    ENT_FREE,
    ENT_MARKED,
    ENT_USED,
    ENT_ANY
  } ent_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [13:0] byte_addr, [21:14] byte_value, [37:22] cluster, [38] read_failed, [39] zero
  logic [fbcm_pkg::IN_DATA_W-1:0] s_axis_tdata;
  // [1:0] cmd
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] verdict, [18:3] entry_value, [26:19] read_byte, [42:27] bad_total,
  // [58:43] bad_new, [74:59] bad_in_file, [79:75] zero
  logic [fbcm_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // mirror of the block state
  logic [7:0]  fat_img [FAT_BYTES];
  bit          fat_known [FAT_BYTES];
  int unsigned loaded_addrs [$];
  logic [15:0] n_total = '0;
  logic [15:0] n_new = '0;
  logic [15:0] n_file = '0;
  logic [15:0] clusters_cfg = fbcm_pkg::SMALL_FAT_LIMIT;

  fat_result_t pending_words [$];
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  logic        rcv_hold = 1'b0;
  event        long_stall_start;

  fat_bad_cluster_marker_core #(
    .FAT_BYTES(FAT_BYTES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
  end

  // long receiver hold-off, counted in cycles
  initial begin
    forever begin
      @(long_stall_start);
      @(posedge clk_i);
      rcv_hold = 1'b1;
      repeat (LONG_STALL_CYCLES) @(posedge clk_i);
      rcv_hold = 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatch_count++;
    $display("%0t: mismatch in %s, got %h, want %h", $time, what, got, want);
  endtask

  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // byte offset of a cluster entry under the current layout
  function automatic void entry_place(input logic [15:0] c, output int unsigned off,
                                      output bit small_fat);
    int unsigned cc;
    cc = c;
    small_fat = (clusters_cfg <= fbcm_pkg::SMALL_FAT_LIMIT);
    off = small_fat ? (cc * 3) >> 1 : cc * 2;
  endfunction

  function automatic bit cluster_in_store(input logic [15:0] c);
    int unsigned off;
    int unsigned lim;
    bit          small_fat;
    entry_place(c, off, small_fat);
    lim = clusters_cfg;
    return (c >= 16'd2) && (c <= lim + 1) && (off + 1 < FAT_BYTES);
  endfunction

  // highest cluster whose entry lies in the store
  function automatic int unsigned top_cluster();
    int unsigned lim;
    lim = clusters_cfg + 1;
    if (clusters_cfg > fbcm_pkg::SMALL_FAT_LIMIT && lim > FAT_BYTES / 2 - 1)
      lim = FAT_BYTES / 2 - 1;
    return lim;
  endfunction

  // applies one word to the mirrored state and gives the result word it causes
  function automatic fat_result_t fat_predict(input fbcm_pkg::cmd_e cmd,
                                              input logic [13:0] addr,
                                              input logic [7:0] val, input logic [15:0] c,
                                              input logic failed);
    fat_result_t r;
    int unsigned off;
    bit          small_fat;
    logic [15:0] w;
    logic [15:0] e;
    logic [15:0] mark;
    r = '0;
    case (cmd)
      fbcm_pkg::CMD_LOAD: begin
        if (!fat_known[addr]) loaded_addrs.push_back(32'(addr));
        fat_img[addr] = val;
        fat_known[addr] = 1'b1;
      end
      fbcm_pkg::CMD_READ: r.rd_byte = fat_img[addr];
      fbcm_pkg::CMD_CLEAR: begin
        n_total = '0;
        n_new = '0;
        n_file = '0;
      end
      default: begin
        entry_place(c, off, small_fat);
        if (!cluster_in_store(c)) begin
          r.verdict = fbcm_pkg::VERDICT_RANGE;
        end else begin
          w = {fat_img[off + 1], fat_img[off]};
          mark = small_fat ? {4'h0, fbcm_pkg::MARK12} : fbcm_pkg::MARK16;
          if (!small_fat) e = w;
          else if (c[0]) e = {4'h0, w[15:4]};
          else e = {4'h0, w[11:0]};
          r.entry = e;
          if (e == mark) begin
            n_total = sat_up(n_total);
            r.verdict = fbcm_pkg::VERDICT_ALREADY_BAD;
          end else if (failed) begin
            n_total = sat_up(n_total);
            if (e != 16'h0) begin
              n_file = sat_up(n_file);
              r.verdict = fbcm_pkg::VERDICT_IN_FILE;
            end else begin
              // free entry gets the bad mark, the neighbor nibble stays
              n_new = sat_up(n_new);
              r.verdict = fbcm_pkg::VERDICT_MARKED;
              if (!small_fat) w = fbcm_pkg::MARK16;
              else if (c[0]) w = {fbcm_pkg::MARK12, w[3:0]};
              else w = {w[15:12], fbcm_pkg::MARK12};
              fat_img[off] = w[7:0];
              fat_img[off + 1] = w[15:8];
            end
          end
        end
      end
    endcase
    r.total = n_total;
    r.fresh = n_new;
    r.in_file = n_file;
    return r;
  endfunction

  // result check, oldest expectation first
  always @(posedge clk_i) begin : result_check
    fat_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[18:3], 16'h0);
      end else begin
        want = pending_words.pop_front();
        if (m_axis_tdata[2:0] !== want.verdict)
          report_mismatch("verdict", 16'(m_axis_tdata[2:0]), 16'(want.verdict));
        if (m_axis_tdata[18:3] !== want.entry)
          report_mismatch("entry_value", m_axis_tdata[18:3], want.entry);
        if (m_axis_tdata[26:19] !== want.rd_byte)
          report_mismatch("read_byte", 16'(m_axis_tdata[26:19]), 16'(want.rd_byte));
        if (m_axis_tdata[42:27] !== want.total)
          report_mismatch("bad_total", m_axis_tdata[42:27], want.total);
        if (m_axis_tdata[58:43] !== want.fresh)
          report_mismatch("bad_new", m_axis_tdata[58:43], want.fresh);
        if (m_axis_tdata[74:59] !== want.in_file)
          report_mismatch("bad_in_file", m_axis_tdata[74:59], want.in_file);
      end
    end
  end

  // offer one word, with random gaps before it
  task automatic send_word(input fbcm_pkg::cmd_e cmd, input logic [13:0] addr,
                           input logic [7:0] val, input logic [15:0] c, input logic failed);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {1'b0, failed, c, val, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_words.push_back(fat_predict(cmd, addr, val, c, failed));
    items_sent++;
  endtask

  task automatic load_byte(input int unsigned addr, input logic [7:0] val);
    send_word(fbcm_pkg::CMD_LOAD, 14'(addr), val, 16'($urandom), 1'($urandom));
  endtask

  task automatic read_byte_at(input int unsigned addr);
    send_word(fbcm_pkg::CMD_READ, 14'(addr), 8'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic clear_counters();
    send_word(fbcm_pkg::CMD_CLEAR, 14'($urandom), 8'($urandom), 16'($urandom),
              1'($urandom));
  endtask

  function automatic ent_kind_e pick_kind();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 35) return ENT_FREE;
    if (roll < 55) return ENT_MARKED;
    if (roll < 85) return ENT_USED;
    return ENT_ANY;
  endfunction

  // load both bytes of a cluster entry, keeping the neighbor nibble
  task automatic set_entry(input logic [15:0] c, input ent_kind_e kind);
    int unsigned off;
    bit          small_fat;
    logic [15:0] e;
    logic [15:0] mark;
    logic [3:0]  keep;
    logic [7:0]  b0;
    logic [7:0]  b1;
    entry_place(c, off, small_fat);
    mark = small_fat ? {4'h0, fbcm_pkg::MARK12} : fbcm_pkg::MARK16;
    case (kind)
      ENT_FREE:   e = 16'h0;
      ENT_MARKED: e = mark;
      ENT_USED: begin
        do e = 16'($urandom_range(small_fat ? 4095 : 65535, 1)); while (e == mark);
      end
      default:    e = 16'($urandom) & (small_fat ? 16'h0FFF : 16'hFFFF);
    endcase
    if (!small_fat) begin
      b0 = e[7:0];
      b1 = e[15:8];
    end else if (c[0]) begin
      keep = fat_known[off] ? fat_img[off][3:0] : 4'($urandom);
      b0 = {e[3:0], keep};
      b1 = e[11:4];
    end else begin
      keep = fat_known[off + 1] ? fat_img[off + 1][7:4] : 4'($urandom);
      b0 = e[7:0];
      b1 = {keep, e[11:8]};
    end
    load_byte(off, b0);
    load_byte(off + 1, b1);
  endtask

  // check one cluster; an entry never loaded is prepared first
  task automatic probe_cluster(input logic [15:0] c, input logic failed);
    int unsigned off;
    bit          small_fat;
    entry_place(c, off, small_fat);
    if (cluster_in_store(c) && !(fat_known[off] && fat_known[off + 1]))
      set_entry(c, pick_kind());
    send_word(fbcm_pkg::CMD_CHECK, 14'($urandom), 8'($urandom), c, failed);
  endtask

  // wait for every outstanding result word, input held idle
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cluster_count(input logic [15:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    clusters_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // byte load and read at the store ends and alternating patterns
  task automatic test_byte_access();
    load_byte(0, 8'h00);
    load_byte(FAT_BYTES - 1, 8'hFF);
    load_byte(14'h2AAA, 8'h55);
    load_byte(14'h1555, 8'hAA);
    read_byte_at(0);
    read_byte_at(FAT_BYTES - 1);
    read_byte_at(14'h2AAA);
    read_byte_at(14'h1555);
    load_byte(0, 8'hFF);
    read_byte_at(0);
    clear_counters();
  endtask

  // 12-bit entries: even and odd clusters sharing a byte, every verdict
  task automatic test_small_entries();
    set_entry(2, ENT_FREE);
    set_entry(3, ENT_FREE);
    probe_cluster(2, 1'b1);
    probe_cluster(3, 1'b1);
    probe_cluster(2, 1'b0);
    read_byte_at(4);
    set_entry(4087, ENT_USED);
    probe_cluster(4087, 1'b1);
    set_entry(4086, ENT_USED);
    probe_cluster(4086, 1'b0);
    probe_cluster(0, 1'b1);
    probe_cluster(1, 1'b0);
    probe_cluster(4088, 1'b1);
    probe_cluster(16'hFFFF, 1'b1);
    clear_counters();
  endtask

  // cluster count of one: only cluster 2 is valid
  task automatic test_single_cluster();
    write_cluster_count(16'd1);
    set_entry(2, ENT_USED);
    probe_cluster(2, 1'b1);
    probe_cluster(3, 1'b1);
    probe_cluster(1, 1'b1);
  endtask

  // 16-bit entries, layout edge and end of the store
  task automatic test_large_entries();
    write_cluster_count(fbcm_pkg::SMALL_FAT_LIMIT + 16'd1);
    set_entry(2, ENT_FREE);
    probe_cluster(2, 1'b1);
    probe_cluster(2, 1'b1);
    set_entry(4088, ENT_USED);
    probe_cluster(4088, 1'b1);
    probe_cluster(4089, 1'b1);
    write_cluster_count(16'd65525);
    set_entry(8191, ENT_FREE);
    probe_cluster(8191, 1'b1);
    read_byte_at(FAT_BYTES - 1);
    probe_cluster(8192, 1'b1);
    probe_cluster(65526, 1'b0);
    probe_cluster(16'hFFFF, 1'b1);
  endtask

  // mostly well-formed entry checks, the rest loose loads, reads, odd clusters and clears
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned start;
    int unsigned roll;
    int unsigned off;
    bit          small_fat;
    logic [15:0] c;
    start = items_sent;
    while (items_sent - start < n_words) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        c = 16'($urandom_range(top_cluster(), 2));
        if ($urandom_range(1) == 0) set_entry(c, pick_kind());
        probe_cluster(c, $urandom_range(99) < 65);
        if ($urandom_range(4) == 0) begin
          entry_place(c, off, small_fat);
          read_byte_at(off + $urandom_range(1));
        end
      end else if (roll < 63) begin
        probe_cluster(16'($urandom), 1'($urandom));
      end else if (roll < 70) begin
        case ($urandom_range(5))
          0: c = 16'd0;
          1: c = 16'd1;
          2: c = 16'(top_cluster());
          3: c = 16'(top_cluster() + 1);
          4: c = clusters_cfg + 16'd2;
          default: c = 16'hFFFF;
        endcase
        probe_cluster(c, 1'($urandom));
      end else if (roll < 82) begin
        load_byte($urandom_range(FAT_BYTES - 1), 8'($urandom));
      end else if (roll < 95) begin
        read_byte_at(loaded_addrs[$urandom_range(loaded_addrs.size() - 1)]);
      end else begin
        clear_counters();
      end
    end
  endtask

  // receiver holds off while words keep coming, then the sender waits for all results and sends more
  task automatic test_backpressure();
    -> long_stall_start;
    test_random_traffic(40);
    drain_results();
    test_random_traffic(20);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = fbcm_pkg::CMD_LOAD;
    snd_idle_pct = 32;
    rcv_idle_pct = 60;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_byte_access();
    test_small_entries();
    test_single_cluster();
    test_large_entries();
    write_cluster_count(16'($urandom_range(4086, 2)));
    test_random_traffic(120);

    drain_results();
    snd_idle_pct = 60;
    rcv_idle_pct = 32;
    write_cluster_count(16'($urandom_range(65525, 4087)));
    test_random_traffic(120);

    drain_results();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_cluster_count(fbcm_pkg::SMALL_FAT_LIMIT);
    test_random_traffic(80);
    test_backpressure();

    drain_results();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
